[src/srlc_pkg.sv]
// Shared types, codes and constants of the selective-repeat link controller.
package srlc_pkg;

   localparam int BITMAP_BYTES  = 32;
   localparam int RESEND_LENGTH = 35;
   localparam int BYTE_IDX_W    = 5;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   localparam logic [2:0] OP_MSG           = 3'd0;
   localparam logic [2:0] OP_TICK          = 3'd1;
   localparam logic [2:0] OP_START_STATUS  = 3'd2;
   localparam logic [2:0] OP_START_IMAGING = 3'd3;
   localparam logic [2:0] OP_START_SETOP   = 3'd4;
   localparam logic [2:0] OP_PING          = 3'd5;

   localparam logic [1:0] PROTO_STATUS  = 2'd0;
   localparam logic [1:0] PROTO_IMAGING = 2'd1;
   localparam logic [1:0] PROTO_SETOP   = 2'd2;
   localparam logic [1:0] PROTO_PING    = 2'd3;

   localparam logic [1:0] KIND_AVAIL  = 2'd0;
   localparam logic [1:0] KIND_PACKET = 2'd1;
   localparam logic [1:0] KIND_PDONE  = 2'd2;
   localparam logic [1:0] KIND_ECHO   = 2'd0;
   localparam logic [1:0] KIND_SDONE  = 2'd1;
   localparam logic [1:0] KIND_PONG   = 2'd0;

   localparam logic [3:0] SK_STATUS_REQ   = 4'd0;
   localparam logic [3:0] SK_IMAGING_REQ  = 4'd1;
   localparam logic [3:0] SK_SETOP        = 4'd2;
   localparam logic [3:0] SK_PING_REQ     = 4'd3;
   localparam logic [3:0] SK_STATUS_START = 4'd4;
   localparam logic [3:0] SK_STATUS_DONE  = 4'd5;
   localparam logic [3:0] SK_IMAGING_START = 4'd6;
   localparam logic [3:0] SK_IMAGING_DONE = 4'd7;
   localparam logic [3:0] SK_RESEND       = 4'd8;
   localparam logic [3:0] SK_SETOP_DONE   = 4'd9;

   localparam logic [6:0] LEN_SHORT = 7'd2;
   localparam logic [6:0] LEN_SETOP = 7'd3;

   localparam logic CSR_SWITCHES = 1'b0;
   localparam logic CSR_TIMEOUT  = 1'b1;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] msg_protocol;
      logic [1:0] msg_kind;
      logic [7:0] packet_count;
      logic [7:0] packet_index;
      logic [7:0] echo_byte;
   } req_type;

   typedef struct packed {
      logic                  send_valid;
      logic [1:0]            send_protocol;
      logic [3:0]            send_kind;
      logic [6:0]            send_length;
      logic [7:0]            payload_byte;
      logic [BYTE_IDX_W-1:0] byte_index;
      logic                  last;
      logic                  busy_res;
      logic                  timed_out;
      logic                  message_done;
      logic                  ping_seen;
   } rsp_type;

   typedef enum logic [1:0] {
      BM_NONE,
      BM_FILL,
      BM_CLEAR
   } bm_op_type;

   typedef struct packed {
      bm_op_type             op;
      logic [BYTE_IDX_W-1:0] addr;
      logic [7:0]            count;
      logic [2:0]            bit_sel;
   } bm_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

[src/srlc_req_if.sv]
// Request channel: valid/ready handshake with the input event payload.
interface srlc_req_if;
   logic             valid;
   logic             ready;
   srlc_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[src/srlc_rsp_if.sv]
// Result channel: valid/ready handshake with one outgoing result.
interface srlc_rsp_if;
   logic             valid;
   logic             ready;
   srlc_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[src/selective_repeat_link_controller.sv]
// Ticks, starts, echoes and packet messages load their result into the result register on acceptance.
// Packets-available: result loaded on acceptance, then a bitmap fill of all 32 entries before the next request.
// Packets-done: a scan of all 32 bitmap entries, then one done result or 32 resend results, one per cycle while free.
// Fill, scan and resend each walk the 32-entry bitmap store one byte at a time.
// Reset (synchronous): idle, not busy, counters and bitmap zero, switches 0, timeout 1000.
module selective_repeat_link_controller (
   input  logic        clock,
   input  logic        reset,
   srlc_req_if.sink    req_chan,
   srlc_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data
);
   import srlc_pkg::*;

   logic [4:0]  switches_ff;
   logic [15:0] timeout_ff;
   bm_cmd_type  bm_cmd;
   logic [7:0]  bm_rd_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         switches_ff <= '0;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SWITCHES: switches_ff <= csr_wr_data[4:0];
            CSR_TIMEOUT: timeout_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   srlc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_data      (req_chan.data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_data      (rsp_chan.data),
      .switches      (switches_ff),
      .timeout_ticks (timeout_ff),
      .bm_cmd        (bm_cmd),
      .bm_rd_byte    (bm_rd_byte)
   );

   srlc_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .cmd     (bm_cmd),
      .rd_byte (bm_rd_byte)
   );

endmodule

[src/srlc_bitmap.sv]
// Missing-packet bitmap store with byte fill unit and bit clear.
module srlc_bitmap (
   input  logic                              clock,
   input  logic                              reset,
   input  srlc_pkg::bm_cmd_type              cmd,
   output logic [7:0]                        rd_byte
);
   import srlc_pkg::*;

   logic [7:0] bm_ff [BITMAP_BYTES];
   logic [7:0] fill_byte;
   logic [4:0] hi_byte;

   assign rd_byte = bm_ff[cmd.addr];
   assign hi_byte = cmd.count[7:3];

   // bits b*8+i below count are set
   always_comb begin
      if (cmd.addr < hi_byte) begin
         fill_byte = 8'hFF;
      end else if (cmd.addr == hi_byte) begin
         fill_byte = 8'((9'd1 << cmd.count[2:0]) - 9'd1);
      end else begin
         fill_byte = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BITMAP_BYTES; i++) begin
            bm_ff[i] <= 8'h00;
         end
      end else begin
         case (cmd.op)
            BM_FILL: bm_ff[cmd.addr] <= fill_byte;
            BM_CLEAR: bm_ff[cmd.addr] <= rd_byte & ~(8'd1 << cmd.bit_sel);
            default: ;
         endcase
      end
   end

endmodule

[src/srlc_ctrl.sv]
// Sequencer: event decode, exchange state, bitmap walk and result register.
module srlc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  srlc_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output srlc_pkg::rsp_type    rsp_data,
   input  logic [4:0]           switches,
   input  logic [15:0]          timeout_ticks,
   output srlc_pkg::bm_cmd_type bm_cmd,
   input  logic [7:0]           bm_rd_byte
);
   import srlc_pkg::*;

   localparam logic [BYTE_IDX_W-1:0] IDX_LAST = BYTE_IDX_W'(BITMAP_BYTES - 1);

   state_type             state_ff, state_in;
   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic                  nz_ff, nz_in;
   logic                  busy_ff, busy_in;
   logic [15:0]           cnt_ff, cnt_in;
   logic [1:0]            lastp_ff, lastp_in;
   logic [1:0]            proto_ff, proto_in;
   logic [7:0]            count_ff, count_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   logic                  out_free;
   logic                  accept;

   function automatic rsp_type pkt(logic [1:0] proto, logic [3:0] kind, logic [6:0] len,
                                   logic [7:0] payload, logic [BYTE_IDX_W-1:0] idx);
      rsp_type r;
      r               = '0;
      r.send_valid    = 1'b1;
      r.send_protocol = proto;
      r.send_kind     = kind;
      r.send_length   = len;
      r.payload_byte  = payload;
      r.byte_index    = idx;
      r.last          = 1'b1;
      return r;
   endfunction

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         nz_ff        <= 1'b0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         lastp_ff     <= PROTO_STATUS;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         nz_ff        <= nz_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         lastp_ff     <= lastp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      proto_ff <= proto_in;
      count_ff <= count_in;
      out_ff   <= out_in;
   end

   always_comb begin
      rsp_type r;
      logic    load;
      logic    sent;
      r            = '0;
      load         = 1'b0;
      sent         = 1'b0;
      state_in     = state_ff;
      idx_in       = idx_ff;
      nz_in        = nz_ff;
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      lastp_in     = lastp_ff;
      proto_in     = proto_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      bm_cmd.op      = BM_NONE;
      bm_cmd.addr    = idx_ff;
      bm_cmd.count   = count_ff;
      bm_cmd.bit_sel = req_data.packet_index[2:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               r.last = 1'b1;
               load   = 1'b1;
               case (req_data.op)
                  OP_MSG: begin
                     r.message_done = 1'b1;
                     cnt_in         = '0;
                     if (req_data.msg_protocol inside {PROTO_STATUS, PROTO_IMAGING}) begin
                        case (req_data.msg_kind)
                           KIND_AVAIL: begin
                              r        = pkt(lastp_ff, req_data.msg_protocol[0] ?
                                             SK_IMAGING_START : SK_STATUS_START,
                                             LEN_SHORT, 8'h00, '0);
                              r.message_done = 1'b1;
                              sent     = 1'b1;
                              count_in = req_data.packet_count;
                              idx_in   = '0;
                              state_in = ST_FILL;
                           end
                           KIND_PACKET: begin
                              bm_cmd.addr = req_data.packet_index[7:3];
                              if (6'(req_data.packet_index[7:3]) < 6'(BITMAP_BYTES)) begin
                                 bm_cmd.op = BM_CLEAR;
                              end
                           end
                           KIND_PDONE: begin
                              load     = 1'b0;
                              proto_in = req_data.msg_protocol;
                              idx_in   = '0;
                              nz_in    = 1'b0;
                              state_in = ST_SCAN;
                           end
                           default: busy_in = 1'b0;
                        endcase
                     end else if (req_data.msg_protocol == PROTO_SETOP) begin
                        if (req_data.msg_kind == KIND_ECHO) begin
                           if (req_data.echo_byte == {3'b000, switches}) begin
                              r    = pkt(PROTO_SETOP, SK_SETOP_DONE, LEN_SHORT, 8'h00, '0);
                              sent = 1'b1;
                           end else if (!busy_ff) begin
                              r       = pkt(PROTO_SETOP, SK_SETOP, LEN_SETOP,
                                            {3'b000, switches}, '0);
                              sent    = 1'b1;
                              busy_in = 1'b1;
                           end
                           r.message_done = 1'b1;
                        end else if (req_data.msg_kind == KIND_SDONE) begin
                           busy_in = 1'b0;
                        end
                     end else if (req_data.msg_kind == KIND_PONG) begin
                        r.ping_seen = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     if (busy_ff) begin
                        if (cnt_ff >= timeout_ticks) begin
                           busy_in     = 1'b0;
                           cnt_in      = '0;
                           r.timed_out = 1'b1;
                        end else begin
                           cnt_in = cnt_ff + 16'd1;
                        end
                     end
                  end
                  OP_START_STATUS, OP_START_IMAGING, OP_START_SETOP, OP_PING: begin
                     if (!busy_ff) begin
                        sent = 1'b1;
                        case (req_data.op)
                           OP_START_STATUS: begin
                              r       = pkt(PROTO_STATUS, SK_STATUS_REQ, LEN_SHORT, 8'h00, '0);
                              busy_in = 1'b1;
                           end
                           OP_START_IMAGING: begin
                              r       = pkt(PROTO_IMAGING, SK_IMAGING_REQ, LEN_SHORT,
                                            8'h00, '0);
                              busy_in = 1'b1;
                           end
                           OP_START_SETOP: begin
                              r       = pkt(PROTO_SETOP, SK_SETOP, LEN_SETOP,
                                            {3'b000, switches}, '0);
                              busy_in = 1'b1;
                           end
                           default: r = pkt(PROTO_PING, SK_PING_REQ, LEN_SHORT, 8'h00, '0);
                        endcase
                     end
                  end
                  default: ;
               endcase
               if (sent) begin
                  lastp_in = r.send_protocol;
                  cnt_in   = '0;
               end
               r.busy_res = busy_in;
               if (load) begin
                  out_valid_in = 1'b1;
                  out_in       = r;
               end
            end
         end
         ST_FILL: begin
            bm_cmd.op = BM_FILL;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            nz_in = nz_ff || (bm_rd_byte != 8'h00);
            if (idx_ff != IDX_LAST) begin
               idx_in = idx_ff + 1'b1;
            end else if (out_free) begin
               idx_in = '0;
               if (nz_in) begin
                  state_in = ST_EMIT;
               end else begin
                  r = pkt(proto_ff, proto_ff[0] ? SK_IMAGING_DONE : SK_STATUS_DONE,
                          LEN_SHORT, 8'h00, '0);
                  r.busy_res     = busy_ff;
                  r.message_done = 1'b1;
                  lastp_in       = proto_ff;
                  cnt_in         = '0;
                  out_valid_in   = 1'b1;
                  out_in         = r;
                  state_in       = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               r = pkt(PROTO_IMAGING, SK_RESEND, 7'(RESEND_LENGTH), bm_rd_byte, idx_ff);
               r.last         = (idx_ff == IDX_LAST);
               r.busy_res     = busy_ff;
               r.message_done = 1'b1;
               lastp_in       = PROTO_IMAGING;
               cnt_in         = '0;
               out_valid_in   = 1'b1;
               out_in         = r;
               idx_in         = idx_ff + 1'b1;
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[dv/selective_repeat_link_controller_tb.sv]
// Testbench for the selective-repeat link controller: directed rows, then random exchanges.
`timescale 1ns / 1ps

module selective_repeat_link_controller_tb;
   import srlc_pkg::*;

   localparam logic [2:0] OP_SPARE6   = 3'd6;
   localparam logic [2:0] OP_SPARE7   = 3'd7;
   localparam logic [1:0] KIND_XDONE  = 2'd3;
   localparam logic [1:0] KIND_SPARE2 = 2'd2;
   localparam logic [1:0] KIND_SPARE3 = 2'd3;

   localparam int PHASE_ITEMS  = 80;
   localparam int PHASES       = 5;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 300;
   localparam int QUIET_LIMIT  = 3000;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } link_stim_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_RANDOM,
      RX_PATTERN
   } rx_style_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wr_data;

   srlc_req_if req_if ();
   srlc_rsp_if rsp_if ();

   selective_repeat_link_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mirror of the controller state
   logic        busy_st;
   logic [15:0] silence_cnt;
   logic [1:0]  last_proto_st;
   logic [7:0]  missing_map [BITMAP_BYTES];
   logic [4:0]  switches_cfg;
   logic [15:0] timeout_cfg;

   rsp_type       step_results[$];
   rsp_type       expected_replies[$];
   link_stim_type directed_rows[$];
   link_stim_type request_plan[$];

   int mismatches = 0;
   int burst_left = 0;
   int hold_asked = 0;
   int quiet_cycles = 0;

   function automatic void add_send(input logic [1:0] proto, input logic [3:0] kind,
                                    input logic [6:0] len, input logic [7:0] payload,
                                    input logic [4:0] idx);
      rsp_type r;
      r = '0;
      r.send_valid    = 1'b1;
      r.send_protocol = proto;
      r.send_kind     = kind;
      r.send_length   = len;
      r.payload_byte  = payload;
      r.byte_index    = idx;
      step_results.push_back(r);
      last_proto_st = proto;
      silence_cnt   = '0;
   endfunction

   function automatic void open_exchange(input logic [1:0] proto, input logic [3:0] kind,
                                         input logic [6:0] len, input logic [7:0] payload,
                                         input bit set_busy);
      if (!busy_st) begin
         if (set_busy) busy_st = 1'b1;
         add_send(proto, kind, len, payload, '0);
      end
   endfunction

   function automatic void predict_link_step(input req_type it);
      rsp_type r;
      bit      tmo, msg, pong, empty;
      int      n;
      step_results.delete();
      tmo   = 1'b0;
      msg   = 1'b0;
      pong  = 1'b0;
      empty = 1'b1;
      case (it.op)
         OP_MSG: begin
            msg = 1'b1;
            silence_cnt = '0;
            if (it.msg_protocol inside {PROTO_STATUS, PROTO_IMAGING}) begin
               case (it.msg_kind)
                  KIND_AVAIL: begin
                     for (int b = 0; b < BITMAP_BYTES; b++)
                        for (int i = 0; i < 8; i++)
                           missing_map[b][i] = (b * 8 + i) < it.packet_count;
                     add_send(last_proto_st, (it.msg_protocol == PROTO_IMAGING) ?
                              SK_IMAGING_START : SK_STATUS_START, LEN_SHORT, '0, '0);
                  end
                  KIND_PACKET: begin
                     missing_map[it.packet_index[7:3]][it.packet_index[2:0]] = 1'b0;
                  end
                  KIND_PDONE: begin
                     for (int b = 0; b < BITMAP_BYTES; b++)
                        if (missing_map[b] != '0) empty = 1'b0;
                     if (empty) begin
                        add_send(it.msg_protocol, (it.msg_protocol == PROTO_IMAGING) ?
                                 SK_IMAGING_DONE : SK_STATUS_DONE, LEN_SHORT, '0, '0);
                     end else begin
                        for (int b = 0; b < BITMAP_BYTES; b++)
                           add_send(PROTO_IMAGING, SK_RESEND, 7'(RESEND_LENGTH),
                                    missing_map[b], 5'(b));
                     end
                  end
                  default: busy_st = 1'b0;
               endcase
            end else if (it.msg_protocol == PROTO_SETOP) begin
               if (it.msg_kind == KIND_ECHO) begin
                  if (it.echo_byte == {3'b000, switches_cfg})
                     add_send(PROTO_SETOP, SK_SETOP_DONE, LEN_SHORT, '0, '0);
                  else
                     open_exchange(PROTO_SETOP, SK_SETOP, LEN_SETOP, {3'b000, switches_cfg},
                                   1'b1);
               end else if (it.msg_kind == KIND_SDONE) begin
                  busy_st = 1'b0;
               end
            end else if (it.msg_kind == KIND_PONG) begin
               pong = 1'b1;
            end
         end
         OP_TICK: begin
            if (busy_st) begin
               if (silence_cnt >= timeout_cfg) begin
                  busy_st     = 1'b0;
                  silence_cnt = '0;
                  tmo         = 1'b1;
               end else begin
                  silence_cnt = silence_cnt + 16'd1;
               end
            end
         end
         OP_START_STATUS:  open_exchange(PROTO_STATUS, SK_STATUS_REQ, LEN_SHORT, '0, 1'b1);
         OP_START_IMAGING: open_exchange(PROTO_IMAGING, SK_IMAGING_REQ, LEN_SHORT, '0, 1'b1);
         OP_START_SETOP:   open_exchange(PROTO_SETOP, SK_SETOP, LEN_SETOP,
                                         {3'b000, switches_cfg}, 1'b1);
         OP_PING:          open_exchange(PROTO_PING, SK_PING_REQ, LEN_SHORT, '0, 1'b0);
         default: ;
      endcase
      if (step_results.size() == 0) begin
         r = '0;
         step_results.push_back(r);
      end
      n = step_results.size();
      for (int k = 0; k < n; k++) begin
         step_results[k].last         = (k == n - 1);
         step_results[k].busy_res     = busy_st;
         step_results[k].timed_out    = tmo;
         step_results[k].message_done = msg;
         step_results[k].ping_seen    = pong;
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void compare_reply(input rsp_type want, input rsp_type got);
      check_field("send_valid", want.send_valid, got.send_valid);
      check_field("send_protocol", want.send_protocol, got.send_protocol);
      check_field("send_kind", want.send_kind, got.send_kind);
      check_field("send_length", want.send_length, got.send_length);
      check_field("payload_byte", want.payload_byte, got.payload_byte);
      check_field("byte_index", want.byte_index, got.byte_index);
      check_field("last", want.last, got.last);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("timed_out", want.timed_out, got.timed_out);
      check_field("message_done", want.message_done, got.message_done);
      check_field("ping_seen", want.ping_seen, got.ping_seen);
   endfunction

   function automatic req_type mk_req(input logic [2:0] op, input logic [1:0] proto,
                                      input logic [1:0] kind, input logic [7:0] count,
                                      input logic [7:0] idx, input logic [7:0] echo);
      req_type r;
      r.op           = op;
      r.msg_protocol = proto;
      r.msg_kind     = kind;
      r.packet_count = count;
      r.packet_index = idx;
      r.echo_byte    = echo;
      return r;
   endfunction

   function automatic rsp_type mk_reply(input bit sv, input logic [1:0] proto,
                                        input logic [3:0] kind, input logic [6:0] len,
                                        input logic [7:0] payload, input bit busy,
                                        input bit msg, input bit pong);
      rsp_type r;
      r = '0;
      r.send_valid    = sv;
      r.send_protocol = proto;
      r.send_kind     = kind;
      r.send_length   = len;
      r.payload_byte  = payload;
      r.last          = 1'b1;
      r.busy_res      = busy;
      r.message_done  = msg;
      r.ping_seen     = pong;
      return r;
   endfunction

   function automatic rsp_type quiet_reply(input bit busy, input bit msg, input bit pong);
      return mk_reply(1'b0, '0, '0, '0, '0, busy, msg, pong);
   endfunction

   function automatic void add_row(input req_type it, input bit typed, input rsp_type want);
      link_stim_type s;
      s.item  = it;
      s.typed = typed;
      s.want  = want;
      directed_rows.push_back(s);
   endfunction

   function automatic void plan(input req_type it);
      link_stim_type s;
      s.item  = it;
      s.typed = 1'b0;
      s.want  = '0;
      request_plan.push_back(s);
   endfunction

   function automatic req_type rand_req(input logic [2:0] op);
      req_type     r;
      logic [31:0] raw;
      raw  = $urandom;
      r    = raw[$bits(req_type)-1:0];
      r.op = op;
      return r;
   endfunction

   function automatic req_type rand_msg(input logic [1:0] proto, input logic [1:0] kind);
      req_type r;
      r = rand_req(OP_MSG);
      r.msg_protocol = proto;
      r.msg_kind     = kind;
      return r;
   endfunction

   function automatic void build_directed_rows();
      add_row(mk_req(OP_TICK, '0, '0, '0, '0, '0), 1'b1, quiet_reply(1'b0, 1'b0, 1'b0));
      add_row(mk_req(OP_SPARE6, '1, '1, '1, '1, '1), 1'b1, quiet_reply(1'b0, 1'b0, 1'b0));
      add_row(mk_req(OP_SPARE7, '0, '0, '0, '0, '0), 1'b1, quiet_reply(1'b0, 1'b0, 1'b0));
      add_row(mk_req(OP_PING, '0, '0, '0, '0, '0), 1'b1,
              mk_reply(1'b1, PROTO_PING, SK_PING_REQ, LEN_SHORT, '0, 1'b0, 1'b0, 1'b0));
      add_row(mk_req(OP_MSG, PROTO_PING, KIND_PONG, '0, '0, '0), 1'b1,
              quiet_reply(1'b0, 1'b1, 1'b1));
      add_row(mk_req(OP_MSG, PROTO_PING, KIND_SPARE3, '0, '0, '0), 1'b1,
              quiet_reply(1'b0, 1'b1, 1'b0));
      add_row(mk_req(OP_START_STATUS, '0, '0, '0, '0, '0), 1'b1,
              mk_reply(1'b1, PROTO_STATUS, SK_STATUS_REQ, LEN_SHORT, '0, 1'b1, 1'b0, 1'b0));
      // starts and ping are dropped while an exchange is open
      add_row(mk_req(OP_START_IMAGING, '0, '0, '0, '0, '0), 1'b1,
              quiet_reply(1'b1, 1'b0, 1'b0));
      add_row(mk_req(OP_START_SETOP, '0, '0, '0, '0, '0), 1'b1, quiet_reply(1'b1, 1'b0, 1'b0));
      add_row(mk_req(OP_PING, '0, '0, '0, '0, '0), 1'b1, quiet_reply(1'b1, 1'b0, 1'b0));
      add_row(mk_req(OP_MSG, PROTO_STATUS, KIND_AVAIL, 8'd255, '0, '0), 1'b1,
              mk_reply(1'b1, PROTO_STATUS, SK_STATUS_START, LEN_SHORT, '0, 1'b1, 1'b1, 1'b0));
      add_row(mk_req(OP_MSG, PROTO_STATUS, KIND_PACKET, '0, 8'd255, '0), 1'b1,
              quiet_reply(1'b1, 1'b1, 1'b0));
      add_row(mk_req(OP_MSG, PROTO_STATUS, KIND_PACKET, '0, 8'd0, '0), 1'b1,
              quiet_reply(1'b1, 1'b1, 1'b0));
      add_row(mk_req(OP_MSG, PROTO_STATUS, KIND_PDONE, '0, '0, '0), 1'b0, '0);
      add_row(mk_req(OP_MSG, PROTO_STATUS, KIND_XDONE, '0, '0, '0), 1'b1,
              quiet_reply(1'b0, 1'b1, 1'b0));
      add_row(mk_req(OP_START_IMAGING, '0, '0, '0, '0, '0), 1'b1,
              mk_reply(1'b1, PROTO_IMAGING, SK_IMAGING_REQ, LEN_SHORT, '0, 1'b1, 1'b0, 1'b0));
      add_row(mk_req(OP_MSG, PROTO_IMAGING, KIND_AVAIL, 8'd0, '0, '0), 1'b0, '0);
      add_row(mk_req(OP_MSG, PROTO_IMAGING, KIND_PDONE, '0, '0, '0), 1'b0, '0);
      add_row(mk_req(OP_MSG, PROTO_IMAGING, KIND_XDONE, '0, '0, '0), 1'b1,
              quiet_reply(1'b0, 1'b1, 1'b0));
      add_row(mk_req(OP_START_SETOP, '0, '0, '0, '0, '0), 1'b1,
              mk_reply(1'b1, PROTO_SETOP, SK_SETOP, LEN_SETOP, '0, 1'b1, 1'b0, 1'b0));
      // wrong echo while busy sends nothing
      add_row(mk_req(OP_MSG, PROTO_SETOP, KIND_ECHO, '0, '0, 8'd255), 1'b1,
              quiet_reply(1'b1, 1'b1, 1'b0));
      add_row(mk_req(OP_MSG, PROTO_SETOP, KIND_ECHO, '0, '0, 8'd0), 1'b1,
              mk_reply(1'b1, PROTO_SETOP, SK_SETOP_DONE, LEN_SHORT, '0, 1'b1, 1'b1, 1'b0));
      add_row(mk_req(OP_MSG, PROTO_SETOP, KIND_SDONE, '0, '0, '0), 1'b1,
              quiet_reply(1'b0, 1'b1, 1'b0));
      add_row(mk_req(OP_MSG, PROTO_SETOP, KIND_ECHO, '0, '0, 8'h80), 1'b0, '0);
      add_row(mk_req(OP_MSG, PROTO_SETOP, KIND_SPARE2, '0, '0, '0), 1'b0, '0);
      add_row(mk_req(OP_TICK, '0, '0, '0, '0, '0), 1'b0, '0);
      add_row(mk_req(OP_MSG, PROTO_SETOP, KIND_SDONE, '0, '0, '0), 1'b1,
              quiet_reply(1'b0, 1'b1, 1'b0));
   endfunction

   function automatic void plan_scenario();
      req_type    r;
      logic [1:0] proto;
      int         count, n, pick;
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
         proto = $urandom_range(0, 1) ? PROTO_IMAGING : PROTO_STATUS;
         if ($urandom_range(0, 7) != 0)
            plan(rand_req((proto == PROTO_IMAGING) ? OP_START_IMAGING : OP_START_STATUS));
         case ($urandom_range(0, 9))
            0:       count = 0;
            1:       count = 255;
            2:       count = $urandom_range(0, 255);
            default: count = $urandom_range(1, 20);
         endcase
         r = rand_msg(proto, KIND_AVAIL);
         r.packet_count = 8'(count);
         plan(r);
         if (count <= 20 && $urandom_range(0, 1) == 1) begin
            for (int i = 0; i < count; i++) begin
               r = rand_msg(proto, KIND_PACKET);
               r.packet_index = 8'(i);
               plan(r);
            end
         end else begin
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++) begin
               r = rand_msg(proto, KIND_PACKET);
               if (count > 0 && $urandom_range(0, 5) != 0)
                  r.packet_index = 8'($urandom_range(0, count - 1));
               plan(r);
            end
         end
         if ($urandom_range(0, 4) == 0) plan(rand_req(OP_TICK));
         if ($urandom_range(0, 9) == 0) proto = 2'($urandom_range(0, 1));
         plan(rand_msg(proto, KIND_PDONE));
         if ($urandom_range(0, 3) != 0) plan(rand_msg(proto, KIND_XDONE));
      end else if (pick == 4) begin
         plan(rand_req(OP_START_SETOP));
         r = rand_msg(PROTO_SETOP, KIND_ECHO);
         if ($urandom_range(0, 1) == 1) r.echo_byte = {3'b000, switches_cfg};
         plan(r);
         r = rand_msg(PROTO_SETOP, KIND_ECHO);
         r.echo_byte = {3'b000, switches_cfg};
         plan(r);
         if ($urandom_range(0, 3) != 0) plan(rand_msg(PROTO_SETOP, KIND_SDONE));
      end else if (pick == 5) begin
         plan(rand_req(OP_PING));
         plan(rand_msg(PROTO_PING, 2'($urandom_range(0, 3))));
      end else if (pick <= 7) begin
         if ($urandom_range(0, 1) == 1)
            plan(rand_req(3'($urandom_range(OP_START_STATUS, OP_START_SETOP))));
         n = (timeout_cfg < 12) ? $urandom_range(1, timeout_cfg + 3) : $urandom_range(1, 6);
         for (int i = 0; i < n; i++) plan(rand_req(OP_TICK));
      end else begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            r = rand_req(3'($urandom_range(0, 7)));
            plan(r);
         end
      end
   endfunction

   task automatic send_request(input link_stim_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.data  <= s.item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_link_step(s.item);
      if (s.typed)
         expected_replies.push_back(s.want);
      else
         foreach (step_results[k]) expected_replies.push_back(step_results[k]);
   endtask

   task automatic settle_link();
      req_if.valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      // bitmap fill may still be walking the store
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      if (idx == CSR_SWITCHES)
         switches_cfg = value[4:0];
      else
         timeout_cfg = value;
   endtask

   initial begin
      logic [4:0]  sw;
      logic [15:0] tmo;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_wr_en    <= 1'b0;
      csr_index    <= CSR_SWITCHES;
      csr_wr_data  <= '0;
      busy_st       = 1'b0;
      silence_cnt   = '0;
      last_proto_st = PROTO_STATUS;
      foreach (missing_map[b]) missing_map[b] = '0;
      switches_cfg  = '0;
      timeout_cfg   = TIMEOUT_RESET;
      build_directed_rows();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) send_request(directed_rows[i]);
      for (int ph = 0; ph < PHASES; ph++) begin
         settle_link();
         case (ph)
            0:       begin sw = 5'h1f; tmo = 16'd1; end
            1:       begin sw = 5'h00; tmo = 16'hffff; end
            2:       begin sw = 5'($urandom); tmo = 16'($urandom_range(1, 6)); end
            3:       begin sw = 5'h15; tmo = 16'd2; end
            default: begin sw = 5'($urandom); tmo = TIMEOUT_RESET; end
         endcase
         write_csr(CSR_SWITCHES, {11'd0, sw});
         write_csr(CSR_TIMEOUT, tmo);
         csr_wr_en <= 1'b0;
         if (ph == 0) hold_asked++;
         request_plan.delete();
         while (request_plan.size() < PHASE_ITEMS) plan_scenario();
         foreach (request_plan[i]) send_request(request_plan[i]);
      end
      settle_link();
      if (mismatches == 0)
         $display("selective_repeat_link_controller_tb passed");
      else
         $display("selective_repeat_link_controller_tb failed");
      $finish;
   end

   // result sink: open, random and patterned stretches, plus one long hold-off
   initial begin
      int           hold_left, style_left, served;
      rx_style_type style;
      hold_left  = 0;
      style_left = 0;
      served     = 0;
      style      = RX_OPEN;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (served != hold_asked) begin
            served    = hold_asked;
            hold_left = LONG_HOLD;
            rsp_if.ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = rx_style_type'($urandom_range(0, 2));
               style_left = $urandom_range(10, 80);
            end
            style_left--;
            case (style)
               RX_OPEN:   rsp_if.ready <= 1'b1;
               RX_RANDOM: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               default:   rsp_if.ready <= (style_left % 5) < 2;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_replies.size() == 0) begin
            $error("result with nothing expected: %h", rsp_if.data);
            mismatches++;
         end else begin
            want = expected_replies.pop_front();
            compare_reply(want, rsp_if.data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("selective_repeat_link_controller_tb failed");
         $finish;
      end
   end

endmodule
